/* rtl/core/utbr_pkg.sv */
package utbr_pkg;

  localparam int FB_WIDTH      = 800;
  localparam int FB_HEIGHT     = 480;
  localparam int MAX_GLYPHS    = 128;
  localparam int BITMAP_BYTES  = 8192;
  localparam int MAX_GLYPH_DIM = 63;

  localparam int ROW_BYTES = (FB_WIDTH + 1) / 2;
  localparam int FB_BYTES  = FB_HEIGHT * ROW_BYTES;
  localparam int FB_AW     = $clog2(FB_BYTES);
  localparam int FB_YW     = $clog2(FB_HEIGHT + 1);
  localparam int GT_AW     = $clog2(MAX_GLYPHS);
  localparam int BM_AW     = $clog2(BITMAP_BYTES);

  localparam int CFG_DW = 16;
  localparam int CFG_IW = 2;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] ASCII_LIM  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;

  typedef enum logic [2:0] {
    OP_GLYPH  = 3'd0,
    OP_BITMAP = 3'd1,
    OP_FILL   = 3'd2,
    OP_READ   = 3'd3,
    OP_TEXT   = 3'd4
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_START_X     = 2'd0,
    REG_START_Y     = 2'd1,
    REG_INK_COLOR   = 2'd2,
    REG_GLYPH_COUNT = 2'd3
  } reg_idx_t;

  // one glyph table entry
  typedef struct packed {
    logic [15:0]       code_point;
    logic [5:0]        width;
    logic [5:0]        height;
    logic signed [6:0] x_offset;
    logic signed [6:0] y_offset;
    logic [6:0]        advance;
    logic [17:0]       offset;
  } glyph_t;

  localparam int GT_DW = $bits(glyph_t);

  // decoder result: code points to draw and the pending state left behind
  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] cp0;
    logic [15:0] cp1;
    logic [1:0]  pend_cnt;
    logic [15:0] pend_bytes;
    logic        str_end;
  } dec_t;

endpackage

/* rtl/core/utbr_if.sv */
interface utbr_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [6:0]        glyph_index;
  logic [15:0]       code_point;
  logic [5:0]        glyph_width;
  logic [5:0]        glyph_height;
  logic signed [6:0] x_offset;
  logic signed [6:0] y_offset;
  logic [6:0]        advance;
  logic [17:0]       data_address;
  logic [7:0]        data_byte;
  logic              last;

  modport source (output valid, op, glyph_index, code_point, glyph_width, glyph_height,
                  x_offset, y_offset, advance, data_address, data_byte, last,
                  input ready);
  modport sink (input valid, op, glyph_index, code_point, glyph_width, glyph_height,
                x_offset, y_offset, advance, data_address, data_byte, last,
                output ready);
endinterface

interface utbr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_data;
  logic signed [15:0] cursor_x;
  logic [1:0]         glyphs_drawn;

  modport source (output valid, read_data, cursor_x, glyphs_drawn, input ready);
  modport sink (input valid, read_data, cursor_x, glyphs_drawn, output ready);
endinterface

/* rtl/core/utf8_bitmap_text_rasterizer.sv */
// channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | op, glyph descriptor, data_address, data_byte, last
// out_ch  | out | valid / ready | read_data, cursor_x, glyphs_drawn
// cfg     | in  | cfg_we        | cfg_index, cfg_wdata
//
// one item at a time; load glyph and load bitmap byte go straight to the result, a read passes S_RDF and S_RDC
// a fill sweeps the framebuffer memory one byte a cycle
// a text byte searches the glyph table entry by entry, then reads the bitmap byte and tests the bit of each pixel,
// and reads and writes back the frame byte for each pixel that is set and on screen, per code point (up to two)
// synchronous reset clears control state only; the memories hold garbage until written
// the finished result waits in the output register while the next item is taken
module utf8_bitmap_text_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  utbr_in_if.sink                       in_ch,
  utbr_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [utbr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [utbr_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int FB_AW = utbr_pkg::FB_AW;
  localparam int GT_AW = utbr_pkg::GT_AW;
  localparam int BM_AW = utbr_pkg::BM_AW;
  localparam int FB_YW = utbr_pkg::FB_YW;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_RDF, S_RDC, S_SR_RD, S_SR_CHK, S_GL_RD, S_GL_LD,
    S_PX_RD, S_PX_BIT, S_FB_RD, S_FB_WR, S_STEP, S_ADV, S_NEXT, S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [15:0] start_x_r;
  logic signed [15:0] start_y_r;
  logic [3:0]         ink_r;
  logic [7:0]         gcount_r;

  // text state
  logic signed [15:0] cursor_r;
  logic [1:0]         pend_cnt_r;
  logic [15:0]        pend_bytes_r;

  // accepted item
  logic [17:0]        addr_r;
  logic [3:0]         fill_c_r;
  logic [FB_AW-1:0]   fill_cnt_r;
  logic [7:0]         rd_r;
  logic [1:0]         cnt_r;
  logic               cp_sel_r;
  logic [15:0]        cp0_r;
  logic [15:0]        cp1_r;
  logic               str_end_r;

  // glyph search and draw
  logic [7:0]         srch_i_r;
  logic               q_found_r;
  logic [GT_AW-1:0]   q_idx_r;
  logic [GT_AW-1:0]   k_r;
  utbr_pkg::glyph_t   g_r;
  logic [3:0]         rb_r;
  logic [18:0]        row_base_r;
  logic [5:0]         gx_r;
  logic [5:0]         gy_r;
  logic               bm_ok_r;
  logic [FB_AW-1:0]   pix_addr_r;
  logic               pix_odd_r;

  // output register
  logic               out_valid_r;
  logic [7:0]         out_rd_r;
  logic signed [15:0] out_cx_r;
  logic [1:0]         out_n_r;

  logic               in_xfer;
  logic               out_free;
  utbr_pkg::dec_t     dec;

  // memory ports
  logic               fb_we, fb_re;
  logic [FB_AW-1:0]   fb_waddr, fb_raddr;
  logic [7:0]         fb_wdata, fb_rdata;
  logic               bm_we, bm_re;
  logic [BM_AW-1:0]   bm_waddr;
  logic [7:0]         bm_rdata;
  logic               gt_we, gt_re;
  logic [GT_AW-1:0]   gt_raddr;
  utbr_pkg::glyph_t   gt_wdata, gt_rdata;

  // pixel math
  logic [18:0]        bm_addr;
  logic               bm_in;
  logic               bit_set;
  logic signed [17:0] px, py;
  logic               on_screen;
  logic [FB_AW-1:0]   pix_addr_nxt;
  logic signed [16:0] csum;
  logic [15:0]        cur_cp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rd_r;
  assign out_ch.cursor_x     = out_cx_r;
  assign out_ch.glyphs_drawn = out_n_r;

  utbr_dec u_dec (
    .data_byte  (in_ch.data_byte),
    .last       (in_ch.last),
    .pend_cnt   (pend_cnt_r),
    .pend_bytes (pend_bytes_r),
    .dec        (dec)
  );

  // bitmap fetch address for the current pixel
  assign bm_addr = row_base_r + 19'(gx_r[5:3]);
  assign bm_in   = bm_addr < 19'(utbr_pkg::BITMAP_BYTES);
  assign bit_set = bm_ok_r && bm_rdata[3'd7 - gx_r[2:0]];

  // screen position and clip
  assign px = 18'(cursor_r) + 18'(g_r.x_offset) + 18'(gx_r);
  assign py = 18'(start_y_r) + 18'(g_r.y_offset) + 18'(gy_r);
  assign on_screen = !px[17] && !py[17] &&
                     (px < 18'(utbr_pkg::FB_WIDTH)) && (py < 18'(utbr_pkg::FB_HEIGHT));
  assign pix_addr_nxt = FB_AW'(32'(py[FB_YW-1:0]) * utbr_pkg::ROW_BYTES + 32'(px[17:1]));

  // cursor advance with saturation at the top of the signed range
  assign csum   = 17'(cursor_r) + 17'(g_r.advance);
  assign cur_cp = cp_sel_r ? cp1_r : cp0_r;

  always_comb begin
    fb_we    = 1'b0;
    fb_waddr = pix_addr_r;
    fb_wdata = pix_odd_r ? {fb_rdata[7:4], ink_r} : {ink_r, fb_rdata[3:0]};
    fb_re    = 1'b0;
    fb_raddr = pix_addr_r;
    case (state_r)
      S_FILL: begin
        fb_we    = 1'b1;
        fb_waddr = fill_cnt_r;
        fb_wdata = {fill_c_r, fill_c_r};
      end
      S_FB_WR: fb_we = 1'b1;
      S_RDF: begin
        fb_re    = 1'b1;
        fb_raddr = addr_r[FB_AW-1:0];
      end
      S_FB_RD: fb_re = 1'b1;
      default: ;
    endcase
  end

  assign bm_we    = in_xfer && (in_ch.op == utbr_pkg::OP_BITMAP) &&
                    (in_ch.data_address < 18'(utbr_pkg::BITMAP_BYTES));
  assign bm_waddr = in_ch.data_address[BM_AW-1:0];
  assign bm_re    = (state_r == S_PX_RD) && bm_in;

  assign gt_we    = in_xfer && (in_ch.op == utbr_pkg::OP_GLYPH);
  assign gt_wdata = '{code_point: in_ch.code_point, width: in_ch.glyph_width,
                      height: in_ch.glyph_height, x_offset: in_ch.x_offset,
                      y_offset: in_ch.y_offset, advance: in_ch.advance,
                      offset: in_ch.data_address};
  assign gt_re    = (state_r == S_SR_RD) || (state_r == S_GL_RD);
  assign gt_raddr = (state_r == S_GL_RD) ? k_r : srch_i_r[GT_AW-1:0];

  utbr_ram #(.WIDTH(8), .DEPTH(utbr_pkg::FB_BYTES)) u_frame (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .re(fb_re), .raddr(fb_raddr), .rdata(fb_rdata)
  );

  utbr_ram #(.WIDTH(8), .DEPTH(utbr_pkg::BITMAP_BYTES)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(in_ch.data_byte),
    .re(bm_re), .raddr(bm_addr[BM_AW-1:0]), .rdata(bm_rdata)
  );

  utbr_ram #(.WIDTH(utbr_pkg::GT_DW), .DEPTH(utbr_pkg::MAX_GLYPHS)) u_glyph (
    .clk(clk), .we(gt_we), .waddr(in_ch.glyph_index[GT_AW-1:0]), .wdata(gt_wdata),
    .re(gt_re), .raddr(gt_raddr), .rdata(gt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_x_r    <= '0;
      start_y_r    <= '0;
      ink_r        <= '0;
      gcount_r     <= '0;
      cursor_r     <= '0;
      pend_cnt_r   <= '0;
      pend_bytes_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // a new result in S_DONE takes the register over in the same cycle
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // register writes, only while idle: the user must keep to this, the block itself does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          utbr_pkg::REG_START_X: begin
            start_x_r <= signed'(cfg_wdata);
            cursor_r  <= signed'(cfg_wdata);
          end
          utbr_pkg::REG_START_Y: start_y_r <= signed'(cfg_wdata);
          utbr_pkg::REG_INK_COLOR: ink_r <= cfg_wdata[3:0];
          utbr_pkg::REG_GLYPH_COUNT: begin
            gcount_r <= (cfg_wdata[7:0] > 8'(utbr_pkg::MAX_GLYPHS)) ?
                        8'(utbr_pkg::MAX_GLYPHS) : cfg_wdata[7:0];
          end
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            addr_r     <= in_ch.data_address;
            fill_c_r   <= in_ch.data_byte[3:0];
            fill_cnt_r <= '0;
            rd_r       <= '0;
            cnt_r      <= '0;
            str_end_r  <= 1'b0;
            cp_sel_r   <= 1'b0;
            case (in_ch.op)
              utbr_pkg::OP_FILL: state_r <= S_FILL;
              utbr_pkg::OP_READ: begin
                state_r <= (in_ch.data_address < 18'(utbr_pkg::FB_BYTES)) ? S_RDF : S_DONE;
              end
              utbr_pkg::OP_TEXT: begin
                cnt_r        <= dec.cnt;
                cp0_r        <= dec.cp0;
                cp1_r        <= dec.cp1;
                str_end_r    <= dec.str_end;
                pend_cnt_r   <= dec.pend_cnt;
                pend_bytes_r <= dec.pend_bytes;
                srch_i_r     <= '0;
                q_found_r    <= 1'b0;
                state_r      <= (dec.cnt != 2'd0) ? S_SR_RD : S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end

        // fill sweep, one byte a cycle
        S_FILL: begin
          fill_cnt_r <= fill_cnt_r + 1'b1;
          if (fill_cnt_r == FB_AW'(utbr_pkg::FB_BYTES - 1)) begin
            state_r <= S_DONE;
          end
        end

        S_RDF: state_r <= S_RDC;
        S_RDC: begin
          rd_r    <= fb_rdata;
          state_r <= S_DONE;
        end

        // linear glyph search, '?' remembered as fallback
        S_SR_RD: begin
          if (srch_i_r >= gcount_r) begin
            k_r     <= q_idx_r;
            state_r <= q_found_r ? S_GL_RD : S_NEXT;
          end else begin
            state_r <= S_SR_CHK;
          end
        end
        S_SR_CHK: begin
          srch_i_r <= srch_i_r + 1'b1;
          if (gt_rdata.code_point == cur_cp) begin
            k_r     <= srch_i_r[GT_AW-1:0];
            state_r <= S_GL_RD;
          end else begin
            if (!q_found_r && (gt_rdata.code_point == {8'h00, utbr_pkg::QMARK})) begin
              q_found_r <= 1'b1;
              q_idx_r   <= srch_i_r[GT_AW-1:0];
            end
            state_r <= S_SR_RD;
          end
        end

        S_GL_RD: state_r <= S_GL_LD;
        S_GL_LD: begin
          g_r        <= gt_rdata;
          rb_r       <= 4'((7'(gt_rdata.width) + 7'd7) >> 3);
          row_base_r <= 19'(gt_rdata.offset);
          gx_r       <= '0;
          gy_r       <= '0;
          state_r    <= ((gt_rdata.width == 6'd0) || (gt_rdata.height == 6'd0)) ?
                        S_ADV : S_PX_RD;
        end

        // per pixel: fetch bitmap byte, test bit, read-modify-write the frame byte
        S_PX_RD: begin
          bm_ok_r <= bm_in;
          state_r <= S_PX_BIT;
        end
        S_PX_BIT: begin
          pix_addr_r <= pix_addr_nxt;
          pix_odd_r  <= px[0];
          state_r    <= (bit_set && on_screen) ? S_FB_RD : S_STEP;
        end
        S_FB_RD: state_r <= S_FB_WR;
        S_FB_WR: state_r <= S_STEP;
        S_STEP: begin
          if (gx_r == g_r.width - 6'd1) begin
            gx_r       <= '0;
            gy_r       <= gy_r + 6'd1;
            row_base_r <= row_base_r + 19'(rb_r);
            state_r    <= (gy_r == g_r.height - 6'd1) ? S_ADV : S_PX_RD;
          end else begin
            gx_r    <= gx_r + 6'd1;
            state_r <= S_PX_RD;
          end
        end

        S_ADV: begin
          cursor_r <= (!csum[16] && csum[15]) ? 16'sd32767 : csum[15:0];
          state_r  <= S_NEXT;
        end

        // second code point of this byte, if any
        S_NEXT: begin
          if (!cp_sel_r && (cnt_r == 2'd2)) begin
            cp_sel_r  <= 1'b1;
            srch_i_r  <= '0;
            q_found_r <= 1'b0;
            state_r   <= S_SR_RD;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= rd_r;
            out_cx_r    <= cursor_r;
            out_n_r     <= cnt_r;
            if (str_end_r) begin
              cursor_r <= start_x_r;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/utbr_ram.sv */
module utbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/utbr_dec.sv */
module utbr_dec (
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic [1:0]          pend_cnt,
  input  logic [15:0]         pend_bytes,
  output utbr_pkg::dec_t      dec
);

  logic [7:0] lead;
  logic [7:0] mid;
  logic       b_ascii;
  logic       b_lead;
  logic       l_lead2;
  logic       m_ascii;

  assign lead    = (pend_cnt == 2'd1) ? pend_bytes[7:0] : pend_bytes[15:8];
  assign mid     = pend_bytes[7:0];
  assign b_ascii = data_byte < utbr_pkg::ASCII_LIM;
  assign b_lead  = ((data_byte & utbr_pkg::LEAD2_MASK) == utbr_pkg::LEAD2_VAL) ||
                   ((data_byte & utbr_pkg::LEAD3_MASK) == utbr_pkg::LEAD3_VAL);
  assign l_lead2 = (lead & utbr_pkg::LEAD2_MASK) == utbr_pkg::LEAD2_VAL;
  assign m_ascii = mid < utbr_pkg::ASCII_LIM;

  always_comb begin
    dec            = '0;
    dec.pend_cnt   = pend_cnt;
    dec.pend_bytes = pend_bytes;
    dec.str_end    = (data_byte == 8'h00) || last;
    if (data_byte == 8'h00) begin
      // string end: flush what is pending
      if (pend_cnt == 2'd1) begin
        dec.cnt = 2'd1;
        dec.cp0 = {8'h00, utbr_pkg::QMARK};
      end else if (pend_cnt != 2'd0) begin
        dec.cnt = 2'd2;
        dec.cp0 = {8'h00, utbr_pkg::QMARK};
        dec.cp1 = {8'h00, m_ascii ? mid : utbr_pkg::QMARK};
      end
    end else if (pend_cnt == 2'd0) begin
      if (b_ascii) begin
        dec.cnt = 2'd1;
        dec.cp0 = {8'h00, data_byte};
      end else if (b_lead && !last) begin
        dec.pend_cnt   = 2'd1;
        dec.pend_bytes = {8'h00, data_byte};
      end else begin
        dec.cnt = 2'd1;
        dec.cp0 = {8'h00, utbr_pkg::QMARK};
      end
    end else if (pend_cnt == 2'd1) begin
      if (l_lead2) begin
        dec.cnt      = 2'd1;
        dec.cp0      = {5'd0, lead[4:0], data_byte[5:0]};
        dec.pend_cnt = 2'd0;
      end else if (last) begin
        // cut-off three byte lead, the byte after it decoded afresh
        dec.cnt      = 2'd2;
        dec.cp0      = {8'h00, utbr_pkg::QMARK};
        dec.cp1      = {8'h00, b_ascii ? data_byte : utbr_pkg::QMARK};
        dec.pend_cnt = 2'd0;
      end else begin
        dec.pend_cnt   = 2'd2;
        dec.pend_bytes = {lead, data_byte};
      end
    end else begin
      dec.cnt      = 2'd1;
      dec.cp0      = {lead[3:0], mid[5:0], data_byte[5:0]};
      dec.pend_cnt = 2'd0;
    end
    if (dec.str_end) begin
      dec.pend_cnt   = 2'd0;
      dec.pend_bytes = '0;
    end
  end

endmodule

/* rtl/core/utbr_chk.sv */
module utbr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_glyphs_drawn
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: intake closes right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a byte never yields more than two code points
  a_glyph_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_glyphs_drawn != 2'd3)
    else $error("glyph count out of range");

  // no result straight after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_bitmap_text_rasterizer utbr_chk u_utbr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_glyphs_drawn (out_ch.glyphs_drawn)
);

/* tb/utf8_bitmap_text_rasterizer_test.sv */
module utf8_bitmap_text_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 30_000_000;
  localparam int BIG_A = 5;           // 63x63 glyph on the low bitmap area
  localparam int BIG_B = 6;           // 63x63 glyph running off the bitmap end
  localparam int QM_SLOT = 100;       // only entry that holds the fallback glyph
  localparam int HI_BASE = 8150;      // written tail of the bitmap store

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  gi;
    logic [15:0] cp;
    logic [5:0]  w;
    logic [5:0]  h;
    logic [6:0]  xo;
    logic [6:0]  yo;
    logic [6:0]  adv;
    logic [17:0] addr;
    logic [7:0]  db;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic [15:0] cx;
    logic [1:0]  n;
  } result_t;

  typedef struct {
    item_t   it;
    result_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [utbr_pkg::CFG_IW-1:0] cfg_index;
  logic [utbr_pkg::CFG_DW-1:0] cfg_wdata;

  utbr_in_if  in_ch ();
  utbr_out_if out_ch ();

  utf8_bitmap_text_rasterizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the block's memories and registers
  logic [7:0]  frame_img [utbr_pkg::FB_BYTES];
  logic [7:0]  bmp_img [utbr_pkg::BITMAP_BYTES];
  logic [15:0] g_cp [utbr_pkg::MAX_GLYPHS];
  int          g_w [utbr_pkg::MAX_GLYPHS];
  int          g_h [utbr_pkg::MAX_GLYPHS];
  int          g_xo [utbr_pkg::MAX_GLYPHS];
  int          g_yo [utbr_pkg::MAX_GLYPHS];
  int          g_adv [utbr_pkg::MAX_GLYPHS];
  int          g_off [utbr_pkg::MAX_GLYPHS];
  int          start_x_r;
  int          start_y_r;
  logic [3:0]  ink_r;
  int          gcount_r;
  logic [15:0] pend_bytes;
  int          pend_cnt;
  int          pen_x;
  int          drawn;

  result_t owed_results[$];
  int      mismatches;
  int      cycles;
  int      n_text;
  int      n_glyphs;
  int      n_reads;
  int      n_items;
  bit      quiet;          // no idling on either side while set
  int      stall_left;

  always #10 clk = ~clk;

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  function automatic void plot(int x, int y);
    int a;
    if (x < 0 || y < 0 || x >= utbr_pkg::FB_WIDTH || y >= utbr_pkg::FB_HEIGHT) return;
    a = y * utbr_pkg::ROW_BYTES + (x >> 1);
    if (x[0]) frame_img[a] = {frame_img[a][7:4], ink_r};
    else frame_img[a] = {ink_r, frame_img[a][3:0]};
  endfunction

  function automatic void draw_cp(int cpv);
    int k;
    int rb;
    int a;
    logic [7:0] b;
    k = -1;
    for (int i = 0; i < gcount_r; i++) if (k < 0 && g_cp[i] == cpv) k = i;
    for (int i = 0; i < gcount_r; i++) if (k < 0 && g_cp[i] == utbr_pkg::QMARK) k = i;
    drawn++;
    if (k < 0) return;
    rb = (g_w[k] + 7) / 8;
    for (int gy = 0; gy < g_h[k]; gy++) begin
      for (int gx = 0; gx < g_w[k]; gx++) begin
        a = g_off[k] + gy * rb + (gx >> 3);
        b = (a < utbr_pkg::BITMAP_BYTES) ? bmp_img[a] : 8'h00;
        if (b[7 - (gx % 8)]) plot(pen_x + g_xo[k] + gx, start_y_r + g_yo[k] + gy);
      end
    end
    pen_x = pen_x + g_adv[k];
    if (pen_x > 32767) pen_x = 32767;
  endfunction

  function automatic bit is_lead(logic [7:0] b);
    return ((b & utbr_pkg::LEAD2_MASK) == utbr_pkg::LEAD2_VAL) ||
           ((b & utbr_pkg::LEAD3_MASK) == utbr_pkg::LEAD3_VAL);
  endfunction

  // byte seen with nothing pending
  function automatic void fresh_byte(logic [7:0] b, bit at_end);
    if (b < utbr_pkg::ASCII_LIM) draw_cp(b);
    else if (is_lead(b)) begin
      if (at_end) draw_cp(utbr_pkg::QMARK);
      else begin
        pend_bytes = {8'h00, b};
        pend_cnt = 1;
      end
    end else draw_cp(utbr_pkg::QMARK);
  endfunction

  function automatic void decode_byte(logic [7:0] b, bit last);
    logic [7:0] lead;
    logic [7:0] mid;
    if (b == 8'h00) begin
      if (pend_cnt == 1) draw_cp(utbr_pkg::QMARK);
      else if (pend_cnt >= 2) begin
        mid = pend_bytes[7:0];
        pend_cnt = 0;
        draw_cp(utbr_pkg::QMARK);
        fresh_byte(mid, 1'b1);
      end
    end else if (pend_cnt == 0) begin
      fresh_byte(b, last);
    end else if (pend_cnt == 1) begin
      lead = pend_bytes[7:0];
      if ((lead & utbr_pkg::LEAD2_MASK) == utbr_pkg::LEAD2_VAL) begin
        pend_cnt = 0;
        draw_cp({lead[4:0], b[5:0]});
      end else if (last) begin
        pend_cnt = 0;
        draw_cp(utbr_pkg::QMARK);
        fresh_byte(b, 1'b1);
      end else begin
        pend_bytes = {lead, b};
        pend_cnt = 2;
      end
    end else begin
      lead = pend_bytes[15:8];
      mid = pend_bytes[7:0];
      pend_cnt = 0;
      draw_cp({lead[3:0], mid[5:0], b[5:0]});
    end
  endfunction

  function automatic result_t rasterize_step(item_t it);
    result_t r;
    int cx;
    r.rd = 8'h00;
    drawn = 0;
    case (it.op)
      utbr_pkg::OP_GLYPH: begin
        g_cp[it.gi] = it.cp;
        g_w[it.gi] = it.w;
        g_h[it.gi] = it.h;
        g_xo[it.gi] = $signed(it.xo);
        g_yo[it.gi] = $signed(it.yo);
        g_adv[it.gi] = it.adv;
        g_off[it.gi] = it.addr;
      end
      utbr_pkg::OP_BITMAP: if (it.addr < utbr_pkg::BITMAP_BYTES) bmp_img[it.addr] = it.db;
      utbr_pkg::OP_FILL:
        for (int i = 0; i < utbr_pkg::FB_BYTES; i++) frame_img[i] = {it.db[3:0], it.db[3:0]};
      utbr_pkg::OP_READ:
        r.rd = (it.addr < utbr_pkg::FB_BYTES) ? frame_img[it.addr] : 8'h00;
      default: ;
    endcase
    if (it.op == utbr_pkg::OP_TEXT) begin
      decode_byte(it.db, it.last);
      cx = pen_x;
      // string end: decoder flushed, pen back to the start column
      if (it.db == 8'h00 || it.last) begin
        pend_bytes = '0;
        pend_cnt = 0;
        pen_x = start_x_r;
      end
    end else cx = pen_x;
    r.cx = cx[15:0];
    r.n = drawn[1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // all fields random, so unused payload bits toggle too
  function automatic item_t rand_item(logic [2:0] op);
    item_t it;
    it.op = op;
    it.gi = $urandom;
    it.cp = $urandom;
    it.w = $urandom;
    it.h = $urandom;
    it.xo = $urandom;
    it.yo = $urandom;
    it.adv = $urandom;
    it.addr = $urandom;
    it.db = $urandom;
    it.last = $urandom;
    return it;
  endfunction

  function automatic item_t mk(logic [2:0] op, logic [7:0] db, logic [17:0] addr, bit last);
    item_t it;
    it = rand_item(op);
    it.db = db;
    it.addr = addr;
    it.last = last;
    return it;
  endfunction

  // one transfer on the input channel, predicted at acceptance
  task automatic send(item_t it, bit typed = 0, result_t typed_res = '0);
    int g;
    result_t r;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.op = it.op;
    in_ch.glyph_index = it.gi;
    in_ch.code_point = it.cp;
    in_ch.glyph_width = it.w;
    in_ch.glyph_height = it.h;
    in_ch.x_offset = it.xo;
    in_ch.y_offset = it.yo;
    in_ch.advance = it.adv;
    in_ch.data_address = it.addr;
    in_ch.data_byte = it.db;
    in_ch.last = it.last;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = rasterize_step(it);
    owed_results.push_back(typed ? typed_res : r);
    n_items++;
    if (it.op == utbr_pkg::OP_TEXT) n_text++;
    if (it.op == utbr_pkg::OP_READ) n_reads++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // all four registers, written back to back while the block is idle
  task automatic write_regs(int sx, int sy, logic [3:0] ink, int gc);
    logic [utbr_pkg::CFG_DW-1:0] v [4];
    drain();
    v[utbr_pkg::REG_START_X] = sx[15:0];
    v[utbr_pkg::REG_START_Y] = sy[15:0];
    v[utbr_pkg::REG_INK_COLOR] = {12'($urandom), ink};
    v[utbr_pkg::REG_GLYPH_COUNT] = {8'($urandom), gc[7:0]};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = utbr_pkg::reg_idx_t'(i);
      cfg_wdata = v[i];
    end
    @(negedge clk);
    cfg_we = 1'b0;
    start_x_r = $signed(v[utbr_pkg::REG_START_X]);
    pen_x = start_x_r;
    start_y_r = $signed(v[utbr_pkg::REG_START_Y]);
    ink_r = v[utbr_pkg::REG_INK_COLOR][3:0];
    gcount_r = (v[utbr_pkg::REG_GLYPH_COUNT][7:0] > utbr_pkg::MAX_GLYPHS) ?
               utbr_pkg::MAX_GLYPHS : v[utbr_pkg::REG_GLYPH_COUNT][7:0];
  endtask

  // small glyph whose bitmap lies inside the written low area
  function automatic item_t small_glyph(int idx, logic [15:0] cpv);
    item_t it;
    int rb;
    it = rand_item(utbr_pkg::OP_GLYPH);
    it.gi = idx;
    it.cp = cpv;
    it.w = $urandom_range(0, 8);
    it.h = $urandom_range(0, 8);
    rb = (it.w + 7) / 8;
    it.addr = $urandom_range(0, 504 - rb * it.h);
    return it;
  endfunction

  function automatic logic [15:0] pick_cp();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      if ($urandom_range(0, 149) == 0) idx = $urandom_range(BIG_A, BIG_B);
      else begin
        idx = $urandom_range(0, utbr_pkg::MAX_GLYPHS - 1);
        if (idx == BIG_A || idx == BIG_B) idx = 7;
      end
      return (g_cp[idx] == 16'h0000) ? 16'h0041 : g_cp[idx];
    end
    if (r < 95) return $urandom_range(1, 127);
    return $urandom_range(16'h0080, 16'hFFFF);
  endfunction

  // one UTF-8 string, sometimes broken, ending in a byte with last set
  task automatic send_string();
    logic [7:0] bytes[$];
    logic [15:0] c;
    int n;
    int r;
    item_t it;
    n = $urandom_range(1, 5);
    repeat (n) begin
      c = pick_cp();
      if (c < 16'h0080) bytes.push_back(c[7:0]);
      else if (c < 16'h0800) begin
        bytes.push_back({3'b110, c[10:6]});
        bytes.push_back({2'b10, c[5:0]});
      end else begin
        bytes.push_back({4'b1110, c[15:12]});
        bytes.push_back({2'b10, c[11:6]});
        bytes.push_back({2'b10, c[5:0]});
      end
    end
    r = $urandom_range(0, 99);
    if (r < 10 && bytes.size() > 1) void'(bytes.pop_back());           // cut-off tail
    else if (r < 15) bytes.insert($urandom_range(0, bytes.size()), 8'h00);
    else if (r < 20) bytes.insert($urandom_range(0, bytes.size()), 8'($urandom));
    else if (r < 30) begin
      // continuation bytes are not checked: scramble the top bits of one
      n = $urandom_range(0, bytes.size() - 1);
      if (bytes[n][7:6] == 2'b10) bytes[n][7:6] = $urandom;
    end
    for (int i = 0; i < bytes.size(); i++) begin
      it = mk(utbr_pkg::OP_TEXT, bytes[i], $urandom, i == bytes.size() - 1);
      send(it);
    end
  endtask

  task automatic random_part(int quota);
    int start;
    int r;
    item_t it;
    start = n_items;
    while (n_items - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 74) send_string();
      else if (r < 81) begin
        it = rand_item(utbr_pkg::OP_READ);
        if ($urandom_range(0, 3) != 0) it.addr = $urandom_range(0, utbr_pkg::FB_BYTES - 1);
        send(it);
      end else if (r < 87) begin
        it = rand_item(utbr_pkg::OP_BITMAP);
        case ($urandom_range(0, 2))
          0: it.addr = $urandom_range(0, 511);
          1: it.addr = $urandom_range(HI_BASE, utbr_pkg::BITMAP_BYTES - 1);
          default: it.addr = $urandom_range(utbr_pkg::BITMAP_BYTES, 18'h3FFFF);
        endcase
        send(it);
      end else if (r < 91) begin
        r = $urandom_range(7, utbr_pkg::MAX_GLYPHS - 1);
        if (r == QM_SLOT) r = 8;
        send(small_glyph(r, $urandom));
      end else if (r < 94) begin
        send(rand_item(3'($urandom_range(5, 7))));
      end else begin
        send(rand_item(utbr_pkg::OP_TEXT));
      end
    end
  endtask

  // ------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------

  function automatic void flag(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h (cycle %0d)", what, want, got, cycles);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    result_t e;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) flag("unexpected transfer", 16'h0, 16'h0);
      else begin
        e = owed_results.pop_front();
        if (out_ch.read_data !== e.rd) flag("read_data", e.rd, out_ch.read_data);
        if (out_ch.cursor_x !== e.cx) flag("cursor_x", e.cx, out_ch.cursor_x);
        if (out_ch.glyphs_drawn !== e.n) flag("glyphs_drawn", e.n, out_ch.glyphs_drawn);
        n_glyphs += e.n;
      end
    end
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------

  initial begin
    row_t rows[$];
    row_t rw;
    item_t it;
    int sx_set [7] = '{10, 700, -32768, 32700, 32767, -50, 0};
    int sy_set [7] = '{100, 400, -32768, 200, 32767, -20, 0};
    int ink_set [7] = '{15, 7, 0, 9, 3, 12, 5};
    int gc_set [7] = '{128, 64, 0, 128, 200, 101, 50};

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.glyph_index = '0;
    in_ch.code_point = '0;
    in_ch.glyph_width = '0;
    in_ch.glyph_height = '0;
    in_ch.x_offset = '0;
    in_ch.y_offset = '0;
    in_ch.advance = '0;
    in_ch.data_address = '0;
    in_ch.data_byte = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    quiet = 0;
    mismatches = 0;
    cycles = 0;
    n_text = 0;
    n_glyphs = 0;
    n_reads = 0;
    n_items = 0;
    pend_bytes = '0;
    pend_cnt = 0;
    pen_x = 0;
    start_x_r = 0;
    start_y_r = 0;
    ink_r = '0;
    gcount_r = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_regs(0, 0, 4'h0, 0);

    // directed rows: empty glyph table, so every code point is skipped
    rw.it = mk(utbr_pkg::OP_FILL, 8'h5A, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_READ, 0, 0, 0);
    rw.res = '{8'hAA, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_READ, 0, utbr_pkg::FB_BYTES - 1, 0);
    rw.res = '{8'hAA, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_READ, 0, utbr_pkg::FB_BYTES, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_READ, 0, 18'h3FFFF, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(3'd5, 8'h41, 0, 1);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(3'd7, 8'hFF, 18'h3FFFF, 1);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_BITMAP, 8'hFF, utbr_pkg::BITMAP_BYTES, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_BITMAP, 8'hFF, 18'h3FFFF, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h41, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd1}; rows.push_back(rw);
    // lead byte cut off by the string end
    rw.it = mk(utbr_pkg::OP_TEXT, 8'hC3, 0, 1);
    rw.res = '{8'h00, 16'h0, 2'd1}; rows.push_back(rw);
    // zero byte after two pending bytes: lead and middle both fall back
    rw.it = mk(utbr_pkg::OP_TEXT, 8'hE2, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h82, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h00, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd2}; rows.push_back(rw);
    // zero byte after one pending lead
    rw.it = mk(utbr_pkg::OP_TEXT, 8'hE2, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h00, 0, 1);
    rw.res = '{8'h00, 16'h0, 2'd1}; rows.push_back(rw);
    // invalid lead and stray continuation
    rw.it = mk(utbr_pkg::OP_TEXT, 8'hFF, 0, 1);
    rw.res = '{8'h00, 16'h0, 2'd1}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h80, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd1}; rows.push_back(rw);
    // three-byte lead cut off at the second byte: fallback, then fresh 'A'
    rw.it = mk(utbr_pkg::OP_TEXT, 8'hE2, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h41, 0, 1);
    rw.res = '{8'h00, 16'h0, 2'd2}; rows.push_back(rw);
    // lone zero byte draws nothing
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h00, 0, 0);
    rw.res = '{8'h00, 16'h0, 2'd0}; rows.push_back(rw);
    rw.it = mk(utbr_pkg::OP_TEXT, 8'h7F, 0, 1);
    rw.res = '{8'h00, 16'h0, 2'd1}; rows.push_back(rw);
    foreach (rows[i]) send(rows[i].it, 1'b1, rows[i].res);

    // bitmap areas that glyphs point into, with dense bytes mixed in
    quiet = 1;
    for (int a = 0; a < 512; a++)
      send(mk(utbr_pkg::OP_BITMAP, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom), a, 0));
    for (int a = HI_BASE; a < utbr_pkg::BITMAP_BYTES; a++)
      send(mk(utbr_pkg::OP_BITMAP, $urandom, a, 0));
    quiet = 0;

    // glyph table: ascii, two-byte and three-byte code points, one fallback glyph
    for (int i = 0; i < utbr_pkg::MAX_GLYPHS; i++) begin
      if (i == BIG_A || i == BIG_B) begin
        it = rand_item(utbr_pkg::OP_GLYPH);
        it.gi = i;
        it.cp = 16'h0040 + i;
        it.w = 6'd63;
        it.h = 6'd63;
        it.addr = (i == BIG_A) ? 0 : HI_BASE;   // second one reads past the store end
      end else if (i == QM_SLOT) it = small_glyph(i, utbr_pkg::QMARK);
      else if (i < 40) it = small_glyph(i, 16'h0040 + i);
      else if (i < 80) it = small_glyph(i, $urandom_range(16'h0080, 16'h07FF));
      else it = small_glyph(i, $urandom_range(16'h0800, 16'hFFFF));
      send(it);
    end

    // phases over register settings, extremes included
    for (int p = 0; p < 7; p++) begin
      quiet = (p % 3 == 1);
      write_regs(sx_set[p], sy_set[p], ink_set[p][3:0], gc_set[p]);
      if (p == 3) send(mk(utbr_pkg::OP_FILL, $urandom, $urandom, $urandom));
      random_part(50);
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d transfers in, %0d text bytes, %0d code points drawn or skipped, %0d reads",
             n_items, n_text, n_glyphs, n_reads);
    $display("seven register settings incl. clipped, saturating and empty-table cases");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
